// ===== rtl/tgd_pkg.sv =====
package tgd_pkg;

	// Coordinate format: signed degrees with this many fraction bits.
	localparam int COORD_FRAC_BITS = 16;

	// Width of the signed value handed to the angle converter.
	localparam int COORD_W = 26;

	// Degree-to-binary-angle conversion: (r << TURN_SHIFT + 180) / 360.
	localparam int TURN_SHIFT = 32 - COORD_FRAC_BITS;
	localparam int TURN_DIV   = 45;
	localparam int TURN_BIAS  = 180 >> 3;
	localparam int FRAC_W     = TURN_SHIFT - 3;
	localparam int QUO_W      = COORD_FRAC_BITS + 3;
	localparam int RES_W      = COORD_FRAC_BITS + 9;
	localparam int REM_W      = $clog2(TURN_DIV);
	localparam logic [RES_W-1:0] TURN_MOD = RES_W'(360 << COORD_FRAC_BITS);

	// Reciprocal of 45 for the reduced coordinate.
	localparam int RECIP_SHIFT = COORD_FRAC_BITS + 20;
	localparam int RECIP_W     = COORD_FRAC_BITS + 15;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TURN_DIV - 1)) / 64'(TURN_DIV));

	typedef logic [FRAC_W-1:0] frac_tbl_t [TURN_DIV];

	function automatic frac_tbl_t build_frac_tbl();
		frac_tbl_t t;
		for (int i = 0; i < TURN_DIV; i++) begin
			t[i] = FRAC_W'(((i << FRAC_W) + TURN_BIAS) / TURN_DIV);
		end
		return t;
	endfunction

	localparam frac_tbl_t FRAC_TBL = build_frac_tbl();

	// CORDIC datapath.
	localparam int CW = 34;
	localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;
	localparam logic [31:0] ATAN_TURN [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	// Integer square root of a Q60 value.
	localparam int SQ_IN_W   = 61;
	localparam int ISQ_W     = 62;
	localparam int ISQ_STEPS = 31;
	localparam int ROOT_W    = 31;

	// Distance scaling: round(256 * 6371 * 4 * pi) and the half circumference.
	localparam logic [24:0] DIST_SCALE = 25'd20495449;
	localparam logic [22:0] HALF_CIRC  = 23'd5123862;
	localparam int DIST_W = 23;

	typedef enum logic [1:0] {
		REG_CENTER_LAT = 2'd0,
		REG_CENTER_LON = 2'd1,
		REG_RADIUS     = 2'd2
	} cfg_reg_t;

endpackage

// ===== rtl/tgd_turn.sv =====
module tgd_turn (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [tgd_pkg::COORD_W-1:0]   coord,
	output logic        [31:0]                   turn
);

	localparam int XW = tgd_pkg::COORD_W + 1;
	localparam int PW = tgd_pkg::RES_W + tgd_pkg::RECIP_W;

	logic signed [XW-1:0] xw;
	logic signed [XW-1:0] mw;
	logic signed [XW-1:0] rw;

	logic [tgd_pkg::RES_W-1:0] r_s1;
	logic [tgd_pkg::RES_W-1:0] r_s2;
	logic [tgd_pkg::QUO_W-1:0] qa_s2;
	logic [tgd_pkg::QUO_W-1:0] qa_s3;
	logic [tgd_pkg::REM_W-1:0] ra_s3;
	logic [PW-1:0]             qprod;
	logic [tgd_pkg::RES_W-1:0] rem;

	assign xw = {coord[tgd_pkg::COORD_W-1], coord};
	assign mw = signed'(XW'(tgd_pkg::TURN_MOD));

	// Reduce into one turn of degrees.
	always_comb begin
		if (xw < -mw) begin
			rw = xw + (mw <<< 1);
		end else if (xw < 0) begin
			rw = xw + mw;
		end else if (xw >= mw) begin
			rw = xw - mw;
		end else begin
			rw = xw;
		end
	end

	assign qprod = PW'(r_s1) * PW'(tgd_pkg::RECIP);
	assign rem   = r_s2 - tgd_pkg::RES_W'(qa_s2 * tgd_pkg::TURN_DIV);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1  <= rw[tgd_pkg::RES_W-1:0];
			r_s2  <= r_s1;
			qa_s2 <= qprod[tgd_pkg::RECIP_SHIFT +: tgd_pkg::QUO_W];
			qa_s3 <= qa_s2;
			ra_s3 <= rem[tgd_pkg::REM_W-1:0];
			turn  <= {qa_s3, tgd_pkg::FRAC_TBL[ra_s3]};
		end
	end

endmodule

// ===== rtl/tgd_sincos.sv =====
module tgd_sincos #(
	parameter int STEPS = 20
) (
	input  logic               clk,
	input  logic               en,
	input  logic        [31:0] ang,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);

	localparam int CW = tgd_pkg::CW;
	localparam logic signed [CW-1:0] ONE = CW'(1) <<< 30;

	logic signed [CW-1:0] x_s [STEPS+1];
	logic signed [CW-1:0] y_s [STEPS+1];
	logic signed [CW-1:0] z_s [STEPS+1];
	logic                 neg_s [STEPS+1];

	logic signed [31:0]   z0;
	logic                 neg0;
	logic        [31:0]   zfold;
	logic signed [CW-1:0] xf;
	logic signed [CW-1:0] yf;

	// Fold the angle into the right half plane; the result is negated later.
	assign z0    = signed'(ang);
	assign neg0  = (z0 > (32'sd1 <<< 30)) || (z0 < -(32'sd1 <<< 30));
	assign zfold = neg0 ? {~ang[31], ang[30:0]} : ang;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= signed'(CW'(tgd_pkg::CORDIC_GAIN_INV));
			y_s[0]   <= '0;
			z_s[0]   <= CW'(signed'(zfold));
			neg_s[0] <= neg0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] at;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = signed'(CW'(tgd_pkg::ATAN_TURN[i]));

		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	assign xf = neg_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign yf = neg_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (yf > ONE) begin
				sin_val <= 32'(ONE);
			end else if (yf < -ONE) begin
				sin_val <= 32'(-ONE);
			end else begin
				sin_val <= 32'(yf);
			end
			if (xf > ONE) begin
				cos_val <= 32'(ONE);
			end else if (xf < -ONE) begin
				cos_val <= 32'(-ONE);
			end else begin
				cos_val <= 32'(xf);
			end
		end
	end

endmodule

// ===== rtl/tgd_isqrt.sv =====
module tgd_isqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tgd_pkg::SQ_IN_W-1:0]   val,
	output logic [tgd_pkg::ROOT_W-1:0]    root
);

	localparam int W = tgd_pkg::ISQ_W;
	localparam int N = tgd_pkg::ISQ_STEPS;

	logic [W-1:0] v_s [N];
	logic [W-1:0] r_s [N];

	// One result bit per stage, from the top bit pair down.
	for (genvar k = 0; k < N; k++) begin : g_bit
		localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
		logic [W-1:0] vin;
		logic [W-1:0] rin;
		logic [W-1:0] trial;

		if (k == 0) begin : g_first
			assign vin = W'(val);
			assign rin = '0;
		end else begin : g_next
			assign vin = v_s[k-1];
			assign rin = r_s[k-1];
		end

		assign trial = rin + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (vin >= trial) begin
					v_s[k] <= vin - trial;
					r_s[k] <= (rin >> 1) + BIT;
				end else begin
					v_s[k] <= vin;
					r_s[k] <= rin >> 1;
				end
			end
		end
	end

	assign root = r_s[N-1][tgd_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/tgd_point.sv =====
module tgd_point #(
	parameter int STEPS = 20
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [23:0]              lat,
	input  logic signed [24:0]              lon,
	input  logic signed [23:0]              center_lat,
	input  logic signed [24:0]              center_lon,
	input  logic signed [31:0]              center_cos,
	output logic        [tgd_pkg::DIST_W-1:0] point_dist
);

	localparam int CAW = tgd_pkg::COORD_W;
	localparam int CW  = tgd_pkg::CW;
	localparam int RW  = tgd_pkg::ROOT_W;
	localparam logic [RW-1:0] Q30_ONE = RW'(1) << 30;

	logic signed [CAW-1:0] dlat_s1;
	logic signed [CAW-1:0] dlon_s1;
	logic signed [CAW-1:0] plat_s1;

	logic [31:0] turn_dlat;
	logic [31:0] turn_dlon;
	logic [31:0] turn_plat;

	logic signed [31:0] sin_dlat;
	logic signed [31:0] sin_dlon;
	logic signed [31:0] cos_plat;

	logic signed [63:0] p_lat;
	logic signed [63:0] p_lon;
	logic signed [63:0] p_cc;
	logic signed [63:0] p_t;

	logic        [RW-1:0] slat2_s2;
	logic        [RW-1:0] slon2_s2;
	logic signed [31:0]   cc_s2;
	logic        [RW-1:0] slat2_s3;
	logic signed [31:0]   t_s3;
	logic signed [32:0]   hsum;
	logic        [RW-1:0] a_s4;

	logic [RW-1:0] root_a;
	logic [RW-1:0] root_b;

	logic signed [CW-1:0] vx_s [STEPS];
	logic signed [CW-1:0] vy_s [STEPS];
	logic signed [CW-1:0] vz_s [STEPS];

	logic        [RW-1:0] zc;
	logic        [55:0]   dprod;
	logic        [23:0]   d_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= CAW'(lat) - CAW'(center_lat);
			dlon_s1 <= CAW'(lon) - CAW'(center_lon);
			plat_s1 <= CAW'(lat);
		end
	end

	tgd_turn u_turn_dlat (.clk(clk), .en(en), .coord(dlat_s1), .turn(turn_dlat));
	tgd_turn u_turn_dlon (.clk(clk), .en(en), .coord(dlon_s1), .turn(turn_dlon));
	tgd_turn u_turn_plat (.clk(clk), .en(en), .coord(plat_s1), .turn(turn_plat));

	// Half-angle differences go through the sine unit; only their sines are used.
	tgd_sincos #(.STEPS(STEPS)) u_sc_dlat (
		.clk(clk), .en(en), .ang({1'b0, turn_dlat[31:1]}),
		.sin_val(sin_dlat), .cos_val()
	);
	tgd_sincos #(.STEPS(STEPS)) u_sc_dlon (
		.clk(clk), .en(en), .ang({1'b0, turn_dlon[31:1]}),
		.sin_val(sin_dlon), .cos_val()
	);
	tgd_sincos #(.STEPS(STEPS)) u_sc_plat (
		.clk(clk), .en(en), .ang(turn_plat),
		.sin_val(), .cos_val(cos_plat)
	);

	// Haversine term a = sin^2(dlat/2) + cos(clat) cos(plat) sin^2(dlon/2).
	assign p_lat = sin_dlat * sin_dlat;
	assign p_lon = sin_dlon * sin_dlon;
	assign p_cc  = center_cos * cos_plat;
	assign p_t   = cc_s2 * signed'({1'b0, slon2_s2});
	assign hsum  = signed'({2'b00, slat2_s3}) + {t_s3[31], t_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			slat2_s2 <= p_lat[60:30];
			slon2_s2 <= p_lon[60:30];
			cc_s2    <= p_cc[61:30];
			slat2_s3 <= slat2_s2;
			t_s3     <= p_t[61:30];
			if (hsum < 0) begin
				a_s4 <= '0;
			end else if (hsum > signed'(33'(Q30_ONE))) begin
				a_s4 <= Q30_ONE;
			end else begin
				a_s4 <= hsum[RW-1:0];
			end
		end
	end

	tgd_isqrt u_sqrt_a (.clk(clk), .en(en), .val({a_s4, 30'b0}), .root(root_a));
	tgd_isqrt u_sqrt_b (.clk(clk), .en(en), .val({Q30_ONE - a_s4, 30'b0}), .root(root_b));

	// Vectoring CORDIC drives y to zero; z accumulates the central half-angle.
	for (genvar k = 0; k < STEPS; k++) begin : g_vec
		logic signed [CW-1:0] xi;
		logic signed [CW-1:0] yi;
		logic signed [CW-1:0] zi;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] at;

		if (k == 0) begin : g_first
			assign xi = signed'(CW'(root_b));
			assign yi = signed'(CW'(root_a));
			assign zi = '0;
		end else begin : g_next
			assign xi = vx_s[k-1];
			assign yi = vy_s[k-1];
			assign zi = vz_s[k-1];
		end

		assign dx = yi >>> k;
		assign dy = xi >>> k;
		assign at = signed'(CW'(tgd_pkg::ATAN_TURN[k]));

		always_ff @(posedge clk) begin
			if (en) begin
				if (yi > 0) begin
					vx_s[k] <= xi + dx;
					vy_s[k] <= yi - dy;
					vz_s[k] <= zi + at;
				end else begin
					vx_s[k] <= xi - dx;
					vy_s[k] <= yi + dy;
					vz_s[k] <= zi - at;
				end
			end
		end
	end

	always_comb begin
		if (vz_s[STEPS-1] < 0) begin
			zc = '0;
		end else if (vz_s[STEPS-1] > signed'(CW'(Q30_ONE))) begin
			zc = Q30_ONE;
		end else begin
			zc = vz_s[STEPS-1][RW-1:0];
		end
	end

	assign dprod = 56'(zc) * 56'(tgd_pkg::DIST_SCALE) + (56'(1) << 31);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s5 <= dprod[55:32];
			if (d_s5 > 24'(tgd_pkg::HALF_CIRC)) begin
				point_dist <= tgd_pkg::HALF_CIRC;
			end else begin
				point_dist <= d_s5[tgd_pkg::DIST_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/track_geofence_distance.sv =====
// One transaction is accepted every cycle unless the pipeline halts, as described below.
// The pipeline depth is set by the two CORDIC chains and the 31-stage square root in each lane.
// The whole pipeline halts only while a finished result is held and out_stall is high.
// Reset clears the configuration registers, the pipeline valid bits and out_valid.
module track_geofence_distance #(
	parameter int CORDIC_STEPS = 20
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic        [1:0]  cfg_index,
	input  logic        [24:0] cfg_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] start_lat,
	input  logic signed [24:0] start_lon,
	input  logic signed [23:0] end_lat,
	input  logic signed [24:0] end_lon,

	output logic               out_valid,
	input  logic               out_stall,
	output logic               inside_res,
	output logic        [22:0] nearest_distance
);

	// Valid bits for the input register stage plus every register stage of a lane.
	localparam int DEPTH = 2 * CORDIC_STEPS + 44;
	localparam int DW    = tgd_pkg::DIST_W;

	logic               en;

	logic signed [23:0] center_lat_q;
	logic signed [24:0] center_lon_q;
	logic        [22:0] radius_q;

	logic               vld_s [DEPTH];

	logic signed [24:0] mid_lat_sum;
	logic signed [25:0] mid_lon_sum;
	logic signed [24:0] mid_lat_half;
	logic signed [25:0] mid_lon_half;

	logic signed [23:0] slat_s1;
	logic signed [24:0] slon_s1;
	logic signed [23:0] elat_s1;
	logic signed [24:0] elon_s1;
	logic signed [23:0] mlat_s1;
	logic signed [24:0] mlon_s1;

	logic signed [tgd_pkg::COORD_W-1:0] ctr_lat_s1;
	logic        [31:0]                 ctr_turn;
	logic signed [31:0]                 ctr_cos;

	logic [DW-1:0] d_start;
	logic [DW-1:0] d_end;
	logic [DW-1:0] d_mid;
	logic [DW-1:0] d_min;

	// The pipeline moves whenever the output register is empty or being drained.
	// A held result only stops the pipeline while the downstream side stalls.
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// Configuration writes land in the register named by cfg_index; other
	// indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_lat_q <= '0;
			center_lon_q <= '0;
			radius_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tgd_pkg::REG_CENTER_LAT: center_lat_q <= cfg_data[23:0];
				tgd_pkg::REG_CENTER_LON: center_lon_q <= cfg_data[24:0];
				tgd_pkg::REG_RADIUS:     radius_q     <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	// Midpoint is the plain average of the coordinates, halved toward zero.
	assign mid_lat_sum  = 25'(start_lat) + 25'(end_lat);
	assign mid_lon_sum  = 26'(start_lon) + 26'(end_lon);
	assign mid_lat_half = (mid_lat_sum + 25'(mid_lat_sum < 0)) >>> 1;
	assign mid_lon_half = (mid_lon_sum + 26'(mid_lon_sum < 0)) >>> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			slat_s1 <= start_lat;
			slon_s1 <= start_lon;
			elat_s1 <= end_lat;
			elon_s1 <= end_lon;
			mlat_s1 <= mid_lat_half[23:0];
			mlon_s1 <= mid_lon_half[24:0];
		end
	end

	// The center latitude cosine runs through the same converter and CORDIC as
	// the lane's own latitude, one stage shorter, so it reaches the product stage
	// ahead of the lane cosine. That is harmless only if the user changes
	// configuration while the pipeline is empty; the block does not enforce it.
	always_ff @(posedge clk) begin
		if (en) begin
			ctr_lat_s1 <= tgd_pkg::COORD_W'(center_lat_q);
		end
	end

	tgd_turn u_ctr_turn (.clk(clk), .en(en), .coord(ctr_lat_s1), .turn(ctr_turn));

	tgd_sincos #(.STEPS(CORDIC_STEPS)) u_ctr_sc (
		.clk(clk), .en(en), .ang(ctr_turn), .sin_val(), .cos_val(ctr_cos)
	);

	// Three identical lanes: start point, end point and midpoint.
	tgd_point #(.STEPS(CORDIC_STEPS)) u_lane_start (
		.clk(clk), .en(en), .lat(slat_s1), .lon(slon_s1),
		.center_lat(center_lat_q), .center_lon(center_lon_q),
		.center_cos(ctr_cos), .point_dist(d_start)
	);

	tgd_point #(.STEPS(CORDIC_STEPS)) u_lane_end (
		.clk(clk), .en(en), .lat(elat_s1), .lon(elon_s1),
		.center_lat(center_lat_q), .center_lon(center_lon_q),
		.center_cos(ctr_cos), .point_dist(d_end)
	);

	tgd_point #(.STEPS(CORDIC_STEPS)) u_lane_mid (
		.clk(clk), .en(en), .lat(mlat_s1), .lon(mlon_s1),
		.center_lat(center_lat_q), .center_lon(center_lon_q),
		.center_cos(ctr_cos), .point_dist(d_mid)
	);

	// Valid bits travel alongside the lane data and halt with it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < DEPTH; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Smallest of the three distances; the point is inside when any distance
	// is strictly below the radius.
	always_comb begin
		d_min = d_start;
		if (d_end < d_min) begin
			d_min = d_end;
		end
		if (d_mid < d_min) begin
			d_min = d_mid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_res       <= (d_start < radius_q) || (d_end < radius_q) ||
				(d_mid < radius_q);
			nearest_distance <= d_min;
		end
	end

endmodule

// ===== bench/tgd_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the geofence block, predicts each result from the
// accepted track and the current register settings, and compares in order.
module tgd_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic        [1:0]  cfg_index,
	input  logic        [24:0] cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [23:0] start_lat,
	input  logic signed [24:0] start_lon,
	input  logic signed [23:0] end_lat,
	input  logic signed [24:0] end_lon,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               inside_res,
	input  logic        [22:0] nearest_distance,
	output int                 fail_count,
	output int                 pending_count,
	output int                 result_count,
	output int                 inside_count
);

	localparam int STEPS = 20;
	localparam longint Q30 = 64'sd1 << 30;

	typedef struct packed {
		logic        hit;
		logic [22:0] dist_val;
	} fence_result_t;

	fence_result_t expected_q[$];
	logic signed [23:0] ctr_lat;
	logic signed [24:0] ctr_lon;
	logic        [22:0] fence_radius;

	function automatic longint asr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [31:0] deg_to_turn(longint deg);
		longint m, r;
		m = longint'(360) << tgd_pkg::COORD_FRAC_BITS;
		r = deg % m;
		if (r < 0)
			r += m;
		return 32'(((r << (32 - tgd_pkg::COORD_FRAC_BITS)) + 180) / 360);
	endfunction

	function automatic void rotate(logic [31:0] ang, output longint s, output longint c);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(ang);
		x = longint'(tgd_pkg::CORDIC_GAIN_INV);
		y = 0;
		flip = 0;
		if (z >= (64'sd1 << 31))
			z -= (64'sd1 << 32);
		if (z > Q30) begin
			z -= (64'sd1 << 31);
			flip = 1;
		end else if (z < -Q30) begin
			z += (64'sd1 << 31);
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(tgd_pkg::ATAN_TURN[i]);
			end else begin
				x += dx; y -= dy; z += longint'(tgd_pkg::ATAN_TURN[i]);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		s = clip(y, -Q30, Q30);
		c = clip(x, -Q30, Q30);
	endfunction

	function automatic longint int_sqrt(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic logic [22:0] great_circle(longint plat, longint plon);
		longint s, c, c1, c2, sl2, so2, a, x, y, z, dx, dy;
		logic [63:0] d;
		rotate(deg_to_turn(plat - ctr_lat) >> 1, s, c);
		sl2 = asr(s * s, 30);
		rotate(deg_to_turn(plon - ctr_lon) >> 1, s, c);
		so2 = asr(s * s, 30);
		rotate(deg_to_turn(ctr_lat), s, c1);
		rotate(deg_to_turn(plat), s, c2);
		a = clip(sl2 + asr(asr(c1 * c2, 30) * so2, 30), 0, Q30);
		y = int_sqrt(64'(a) << 30);
		x = int_sqrt(64'(Q30 - a) << 30);
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(tgd_pkg::ATAN_TURN[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(tgd_pkg::ATAN_TURN[i]);
			end
		end
		z = clip(z, 0, Q30);
		d = (64'(z) * 64'(tgd_pkg::DIST_SCALE) + (64'd1 << 31)) >> 32;
		if (d > 64'(tgd_pkg::HALF_CIRC))
			d = 64'(tgd_pkg::HALF_CIRC);
		return d[22:0];
	endfunction

	function automatic fence_result_t predict_fence(longint sla, longint slo,
			longint ela, longint elo);
		logic [22:0] d0, d1, d2, m;
		fence_result_t r;
		d0 = great_circle(sla, slo);
		d1 = great_circle(ela, elo);
		// Midpoint halves the sum with truncation toward zero.
		d2 = great_circle((sla + ela) / 2, (slo + elo) / 2);
		m = d0;
		if (d1 < m) m = d1;
		if (d2 < m) m = d2;
		r.hit = (d0 < fence_radius) || (d1 < fence_radius) || (d2 < fence_radius);
		r.dist_val = m;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	assign pending_count = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		fence_result_t want;
		if (!arst_n) begin
			ctr_lat <= '0;
			ctr_lon <= '0;
			fence_radius <= '0;
			fail_count = 0;
			result_count = 0;
			inside_count = 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (tgd_pkg::cfg_reg_t'(cfg_index))
					tgd_pkg::REG_CENTER_LAT: ctr_lat <= cfg_data[23:0];
					tgd_pkg::REG_CENTER_LON: ctr_lon <= cfg_data[24:0];
					tgd_pkg::REG_RADIUS:     fence_radius <= cfg_data[22:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_fence(start_lat, start_lon, end_lat, end_lon));
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_q.size() == 0) begin
					report_mismatch("result transactions with nothing expected",
						result_count, 0);
				end else begin
					want = expected_q.pop_front();
					if (inside_res !== want.hit)
						report_mismatch("inside_res", inside_res, want.hit);
					if (nearest_distance !== want.dist_val)
						report_mismatch("nearest_distance", nearest_distance,
							want.dist_val);
					if (want.hit)
						inside_count++;
				end
			end
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the geofence distance block. The checker beside the
// block does all prediction; this module only feeds tracks, stalls the output,
// writes the registers between phases and decides pass or fail.
module testbench;

	localparam int LATENCY = 84;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LAT_MAX = 5898240;
	localparam int LON_MAX = 11796480;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic        [1:0]  cfg_index = '0;
	logic        [24:0] cfg_data = '0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [23:0] start_lat = '0;
	logic signed [24:0] start_lon = '0;
	logic signed [23:0] end_lat = '0;
	logic signed [24:0] end_lon = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic               inside_res;
	logic        [22:0] nearest_distance;
	int                 fail_count, pending_count, result_count, inside_count;
	int                 cycle_count = 0;
	int                 sent_count = 0;

	// The clock runs with 5 ns high and 5 ns low.
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	track_geofence_distance i_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .start_lat, .start_lon, .end_lat, .end_lon,
		.out_valid, .out_stall, .inside_res, .nearest_distance
	);

	tgd_checker i_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .start_lat, .start_lon, .end_lat, .end_lon,
		.out_valid, .out_stall, .inside_res, .nearest_distance,
		.fail_count, .pending_count, .result_count, .inside_count
	);

	// Mostly no gap at all, often a short one, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The receiver stalls at random, in bursts of varied length.
	always @(negedge clk) begin
		if ($urandom_range(0, 99) < 25)
			out_stall <= (gap_length() != 0);
		else if (out_stall && $urandom_range(0, 3) == 0)
			out_stall <= 0;
	end

	// The watchdog ends a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// Presents one transaction and holds it until it is taken, then idles for a random gap, possibly none.
	task automatic send_track(int sla, int slo, int ela, int elo);
		int g;
		start_lat <= 24'(sla);
		start_lon <= 25'(slo);
		end_lat <= 24'(ela);
		end_lon <= 25'(elo);
		in_valid <= 1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
		g = gap_length();
		@(negedge clk);
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	// Ends the input stream and waits until the block has drained.
	task automatic drain();
		in_valid <= 0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic write_reg(tgd_pkg::cfg_reg_t idx, int value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 25'(value);
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic set_fence(int lat, int lon, int rad);
		write_reg(tgd_pkg::REG_CENTER_LAT, lat);
		write_reg(tgd_pkg::REG_CENTER_LON, lon);
		write_reg(tgd_pkg::REG_RADIUS, rad);
	endtask

	function automatic int rand_lat();
		return $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
	endfunction

	function automatic int rand_lon();
		return $urandom_range(0, 2 * LON_MAX) - LON_MAX;
	endfunction

	// Random track near the fence center, so the inside flag toggles often.
	task automatic local_track(int clat, int clon);
		int spread;
		spread = 1 << $urandom_range(8, 21);
		send_track(clat + $signed($urandom_range(0, 2 * spread)) - spread,
			clon + $signed($urandom_range(0, 2 * spread)) - spread,
			clat + $signed($urandom_range(0, 2 * spread)) - spread,
			clon + $signed($urandom_range(0, 2 * spread)) - spread);
	endtask

	// Raw bit patterns reach past the legal degree range on every bit.
	task automatic noise_track();
		send_track($urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		int clat, clon, rad;
		repeat (11) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed part with the reset fence (origin, zero radius).
		send_track(0, 0, 0, 0);
		send_track(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
		send_track(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
		send_track(0, LON_MAX, 0, -LON_MAX);
		send_track(-1, -1, 1, 1);
		drain();

		// Fence at the extremes with a radius beyond half the circumference:
		// everything must come back inside.
		set_fence(LAT_MAX, LON_MAX, 5124096);
		send_track(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX);
		send_track(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
		send_track(0, 0, LAT_MAX, -LON_MAX);
		// Latitudes beyond the poles and the largest raw patterns.
		send_track(24'h7fffff, 25'hffffff, 24'h800000, 25'h1000000);
		send_track(24'h800000, 25'h1000000, 24'h7fffff, 25'hffffff);
		send_track(-LAT_MAX, LON_MAX, -LAT_MAX, LON_MAX - 1);
		drain();

		// Radius at the full register width, then a small fence near the far corner.
		set_fence(-LAT_MAX, -LON_MAX, 23'h7fffff);
		send_track(0, 0, 1, 1);
		send_track(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
		drain();
		set_fence(-LAT_MAX, -LON_MAX, 256);
		send_track(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX);
		send_track(-LAT_MAX + 65536, -LON_MAX, -LAT_MAX, -LON_MAX + 65536);
		send_track(-LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
		drain();

		// Random phases, each with its own fence.
		for (int phase = 0; phase < 8; phase++) begin
			clat = rand_lat();
			clon = rand_lon();
			rad = (phase == 7) ? 0 : $urandom_range(0, 1 << $urandom_range(10, 22));
			set_fence(clat, clon, rad);
			for (int k = 0; k < 100; k++) begin
				if ($urandom_range(0, 9) < 6)
					local_track(clat, clon);
				else if ($urandom_range(0, 1) == 0)
					send_track(rand_lat(), rand_lon(), rand_lat(), rand_lon());
				else
					noise_track();
			end
			drain();
		end

		$display("Sent %0d tracks over several fence settings; %0d results checked, %0d inside.",
			sent_count, result_count, inside_count);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tgd_pkg.sv
rtl/tgd_turn.sv
rtl/tgd_sincos.sv
rtl/tgd_isqrt.sv
rtl/tgd_point.sv
rtl/track_geofence_distance.sv
bench/tgd_checker.sv
bench/testbench.sv
